// File: design/assert_macros.svh
// assertion macros used by the fft magnitude sequencer (fms_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FMS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

`define FMS_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define FMS_ASSERT(label, clk, rstn, prop)

`define FMS_NEVER(label, clk, rstn, cond)

`endif

`endif

// File: design/fms_pkg.sv
// types, constants and twiddle rom of the fft magnitude spectrum block
package fms_pkg;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               frame_end;
    } fms_in_t;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [15:0] magnitude;
        logic        final_bin;
        logic        too_short;
        logic        overflow;
    } fms_out_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SIZE,
        ST_ERR,
        ST_PAD,
        ST_BR_RD,
        ST_BR_W0,
        ST_BR_W1,
        ST_BF_RD,
        ST_BF_M1,
        ST_BF_M2,
        ST_BF_M3,
        ST_BF_WA,
        ST_BF_WQ,
        ST_MG_RD,
        ST_MG_SQ1,
        ST_MG_SQ2,
        ST_MG_SQ3,
        ST_MG_ROOT,
        ST_MG_OUT
    } fms_state_t;

    typedef enum logic [2:0] {
        WS_SAMPLE,
        WS_ZERO,
        WS_RD0,
        WS_RD1,
        WS_SUM,
        WS_DIFF
    } fms_wsrc_t;

    typedef struct packed {
        logic      wr_en;
        fms_wsrc_t wr_src;
        logic      rd_en;
        logic      tw_load;
        logic [5:0] tw_idx;
        logic      mul_a;
        logic      mul_b;
        logic      mul_c;
        logic      sq_re;
        logic      sq_im;
        logic      root_init;
        logic      root_step;
        logic [3:0] mag_shift;
        logic      out_load;
        logic [5:0] out_bin;
        logic      out_final;
        logic      out_short;
        logic      out_ovf;
    } fms_cmd_t;

    typedef struct packed {
        logic out_free;
    } fms_stat_t;

    typedef struct packed {
        logic signed [16:0] c;
        logic signed [16:0] s;
    } fms_tw_t;

    localparam int ROOT_STEPS = 24;

    function automatic logic signed [16:0] fms_cos(input logic [5:0] k);
        logic signed [16:0] v;
        unique case (k)
            6'd0:  v = 17'sd32768;
            6'd1:  v = 17'sd32729;
            6'd2:  v = 17'sd32610;
            6'd3:  v = 17'sd32413;
            6'd4:  v = 17'sd32138;
            6'd5:  v = 17'sd31786;
            6'd6:  v = 17'sd31357;
            6'd7:  v = 17'sd30853;
            6'd8:  v = 17'sd30274;
            6'd9:  v = 17'sd29622;
            6'd10: v = 17'sd28899;
            6'd11: v = 17'sd28106;
            6'd12: v = 17'sd27246;
            6'd13: v = 17'sd26320;
            6'd14: v = 17'sd25330;
            6'd15: v = 17'sd24279;
            6'd16: v = 17'sd23170;
            6'd17: v = 17'sd22006;
            6'd18: v = 17'sd20788;
            6'd19: v = 17'sd19520;
            6'd20: v = 17'sd18205;
            6'd21: v = 17'sd16846;
            6'd22: v = 17'sd15447;
            6'd23: v = 17'sd14010;
            6'd24: v = 17'sd12540;
            6'd25: v = 17'sd11039;
            6'd26: v = 17'sd9512;
            6'd27: v = 17'sd7962;
            6'd28: v = 17'sd6393;
            6'd29: v = 17'sd4808;
            6'd30: v = 17'sd3212;
            6'd31: v = 17'sd1608;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // w = c - j*s for angle 2*pi*k/128
    function automatic fms_tw_t fms_twiddle(input logic [5:0] k);
        fms_tw_t w;
        if (k <= 6'd32) begin
            w.c = fms_cos(k);
            w.s = fms_cos(6'd32 - k);
        end else begin
            w.c = -fms_cos(6'd0 - k);
            w.s = fms_cos(k - 6'd32);
        end
        return w;
    endfunction

endpackage

// File: design/fms_datapath.sv
// working store, butterfly arithmetic, square root and result register
module fms_datapath #(
    parameter int AW = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fms_pkg::fms_cmd_t   cmd,
    output fms_pkg::fms_stat_t  st,
    input  logic signed [15:0]  sample,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       rd_addr0,
    input  logic [AW-1:0]       rd_addr1,
    output logic                m_valid,
    input  logic                m_ready,
    output fms_pkg::fms_out_t   m_item
);
    import fms_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [47:0] mem [DEPTH];
    logic [47:0] rd0_reg, rd1_reg;
    logic [47:0] wr_data;

    logic signed [16:0] c_reg, s_reg;
    logic signed [40:0] p1_reg, p2_reg;
    logic signed [26:0] tr_reg, ti_reg;
    logic [47:0] sq_reg, sq2_reg;
    logic [47:0] x_reg, r_reg, bit_reg;
    logic [47:0] x_next, r_next, trial;
    fms_out_t out_reg;
    logic out_valid_reg;

    logic signed [23:0] ua, ui, br, bi;
    logic signed [27:0] sum_re, sum_im, dif_re, dif_im;
    logic signed [47:0] re_sq, im_sq;
    fms_tw_t tw;
    logic [15:0] mag_sat;

    function automatic logic signed [26:0] rnd15(input logic signed [41:0] v);
        logic [41:0] m;
        logic [41:0] r;
        m = v[41] ? 42'(-v) : 42'(v);
        r = (m + 42'd16384) >> 15;
        return v[41] ? -27'(r) : 27'(r);
    endfunction

    function automatic logic [23:0] sat24(input logic signed [27:0] v);
        logic [23:0] o;
        if (v > 28'sd8388607) begin
            o = 24'h7fffff;
        end else if (v < -28'sd8388608) begin
            o = 24'h800000;
        end else begin
            o = v[23:0];
        end
        return o;
    endfunction

    assign ua = rd0_reg[47:24];
    assign ui = rd0_reg[23:0];
    assign br = rd1_reg[47:24];
    assign bi = rd1_reg[23:0];
    assign sum_re = 28'(ua) + 28'(tr_reg);
    assign sum_im = 28'(ui) + 28'(ti_reg);
    assign dif_re = 28'(ua) - 28'(tr_reg);
    assign dif_im = 28'(ui) - 28'(ti_reg);
    assign re_sq = ua * ua;
    assign im_sq = ui * ui;
    assign tw = fms_twiddle(cmd.tw_idx);

    always_comb begin
        unique case (cmd.wr_src)
            WS_SAMPLE: wr_data = {{8{sample[15]}}, sample, 24'd0};
            WS_ZERO:   wr_data = '0;
            WS_RD0:    wr_data = rd0_reg;
            WS_RD1:    wr_data = rd1_reg;
            WS_SUM:    wr_data = {sat24(sum_re), sat24(sum_im)};
            WS_DIFF:   wr_data = {sat24(dif_re), sat24(dif_im)};
            default:   wr_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    // butterfly products
    always_ff @(posedge aclk) begin
        if (cmd.tw_load) begin
            c_reg <= tw.c;
            s_reg <= tw.s;
        end
        if (cmd.mul_a) begin
            p1_reg <= c_reg * br;
            p2_reg <= s_reg * bi;
        end
        if (cmd.mul_b) begin
            tr_reg <= rnd15(42'(p1_reg) + 42'(p2_reg));
            p1_reg <= c_reg * bi;
            p2_reg <= s_reg * br;
        end
        if (cmd.mul_c) begin
            ti_reg <= rnd15(42'(p1_reg) - 42'(p2_reg));
        end
    end

    // bit-serial square root, two radicand bits a step
    always_comb begin
        trial = r_reg + bit_reg;
        if (x_reg >= trial) begin
            x_next = x_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end else begin
            x_next = x_reg;
            r_next = r_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq_re) begin
            sq_reg <= unsigned'(re_sq);
        end
        if (cmd.sq_im) begin
            sq2_reg <= unsigned'(im_sq);
        end
        if (cmd.root_init) begin
            x_reg   <= (sq_reg + sq2_reg) >> cmd.mag_shift;
            r_reg   <= '0;
            bit_reg <= 48'd1 << 46;
        end else if (cmd.root_step) begin
            x_reg   <= x_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign mag_sat = (r_reg[47:16] != '0) ? 16'hffff : r_reg[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.bin_index <= cmd.out_bin;
            out_reg.magnitude <= cmd.out_short ? 16'd0 : mag_sat;
            out_reg.final_bin <= cmd.out_final;
            out_reg.too_short <= cmd.out_short;
            out_reg.overflow  <= cmd.out_ovf;
        end
    end

    assign st.out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

endmodule

// File: design/fms_ctrl.sv
// sequencer for load, padding, bit reversal, butterfly passes and bin output
`include "assert_macros.svh"

module fms_ctrl #(
    parameter int AW = 7
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  fms_pkg::fms_stat_t  st,
    output fms_pkg::fms_cmd_t   cmd,
    output logic [AW-1:0]       wr_addr,
    output logic [AW-1:0]       rd_addr0,
    output logic [AW-1:0]       rd_addr1
);
    import fms_pkg::*;

    localparam int CW  = AW + 1;
    localparam int LGW = $clog2(AW + 1);
    localparam logic [CW-1:0]  CAP_C = {1'b1, {AW{1'b0}}};
    localparam logic [LGW-1:0] AW_L  = LGW'(AW);

    fms_state_t state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           ovf_reg, ovf_next;
    logic [LGW-1:0] lg_reg, lg_next;
    logic [LGW-1:0] stage_reg, stage_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [4:0]     step_reg, step_next;

    logic [CW-1:0]  n_val, nm1, hm1, half_s, smask, j_off, a_pos, q_pos;
    logic [AW-1:0]  i_a, rev_full, rev_i;
    logic [LGW-1:0] lg_calc;
    logic [6:0]     tw7;

    always_comb begin
        n_val  = CW'(1) << lg_reg;
        nm1    = n_val - 1'b1;
        hm1    = (n_val >> 1) - 1'b1;
        half_s = CW'(1) << (stage_reg - 1'b1);
        smask  = half_s - 1'b1;
        j_off  = idx_reg & smask;
        a_pos  = ((idx_reg & ~smask) << 1) | j_off;
        q_pos  = a_pos | half_s;
        tw7    = 7'(j_off) << (3'd7 - 3'(stage_reg));
        i_a    = idx_reg[AW-1:0];
        for (int b = 0; b < AW; b++) begin
            rev_full[AW-1-b] = i_a[b];
        end
        rev_i = rev_full >> (AW_L - lg_reg);
        lg_calc = '0;
        for (int l = AW; l >= 0; l--) begin
            if ((CW'(1) << l) >= cnt_reg) begin
                lg_calc = LGW'(l);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            lg_reg    <= LGW'(1);
            stage_reg <= LGW'(1);
            idx_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            lg_reg    <= lg_next;
            stage_reg <= stage_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        lg_next    = lg_reg;
        stage_next = stage_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        wr_addr    = i_a;
        rd_addr0   = i_a;
        rd_addr1   = i_a;
        cmd           = '0;
        cmd.wr_src    = WS_ZERO;
        cmd.tw_idx    = tw7[5:0];
        cmd.mag_shift = 4'({lg_reg - 1'b1, 1'b0});
        cmd.out_bin   = 6'(idx_reg);
        cmd.out_ovf   = ovf_reg;
        unique case (state_reg)
            ST_LOAD: begin
                in_ready = aresetn;
                if (in_valid) begin
                    if (cnt_reg < CAP_C) begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = WS_SAMPLE;
                        wr_addr    = cnt_reg[AW-1:0];
                        cnt_next   = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (in_last) begin
                        state_next = ST_SIZE;
                    end
                end
            end
            ST_SIZE: begin
                if (cnt_reg < CW'(2)) begin
                    state_next = ST_ERR;
                end else begin
                    lg_next    = lg_calc;
                    idx_next   = cnt_reg;
                    state_next = ST_PAD;
                end
            end
            ST_ERR: begin
                if (st.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_bin   = '0;
                    cmd.out_final = 1'b1;
                    cmd.out_short = 1'b1;
                    cnt_next      = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            ST_PAD: begin
                if (idx_reg == n_val) begin
                    idx_next   = '0;
                    state_next = ST_BR_RD;
                end else begin
                    cmd.wr_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            ST_BR_RD: begin
                if (i_a < rev_i) begin
                    cmd.rd_en  = 1'b1;
                    rd_addr1   = rev_i;
                    state_next = ST_BR_W0;
                end else if (idx_reg == nm1) begin
                    stage_next = LGW'(1);
                    idx_next   = '0;
                    state_next = ST_BF_RD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_BR_W0: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_RD1;
                state_next = ST_BR_W1;
            end
            ST_BR_W1: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_RD0;
                wr_addr    = rev_i;
                if (idx_reg == nm1) begin
                    stage_next = LGW'(1);
                    idx_next   = '0;
                    state_next = ST_BF_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_BR_RD;
                end
            end
            ST_BF_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.tw_load = 1'b1;
                rd_addr0    = a_pos[AW-1:0];
                rd_addr1    = q_pos[AW-1:0];
                state_next  = ST_BF_M1;
            end
            ST_BF_M1: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_BF_M2;
            end
            ST_BF_M2: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_BF_M3;
            end
            ST_BF_M3: begin
                cmd.mul_c  = 1'b1;
                state_next = ST_BF_WA;
            end
            ST_BF_WA: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_SUM;
                wr_addr    = a_pos[AW-1:0];
                state_next = ST_BF_WQ;
            end
            ST_BF_WQ: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_DIFF;
                wr_addr    = q_pos[AW-1:0];
                if (idx_reg == hm1) begin
                    idx_next = '0;
                    if (stage_reg == lg_reg) begin
                        state_next = ST_MG_RD;
                    end else begin
                        stage_next = stage_reg + 1'b1;
                        state_next = ST_BF_RD;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_BF_RD;
                end
            end
            ST_MG_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MG_SQ1;
            end
            ST_MG_SQ1: begin
                cmd.sq_re  = 1'b1;
                state_next = ST_MG_SQ2;
            end
            ST_MG_SQ2: begin
                cmd.sq_im  = 1'b1;
                state_next = ST_MG_SQ3;
            end
            ST_MG_SQ3: begin
                cmd.root_init = 1'b1;
                step_next     = '0;
                state_next    = ST_MG_ROOT;
            end
            ST_MG_ROOT: begin
                cmd.root_step = 1'b1;
                if (step_reg == 5'(ROOT_STEPS - 1)) begin
                    state_next = ST_MG_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_MG_OUT: begin
                if (st.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_final = (idx_reg == hm1);
                    if (idx_reg == hm1) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MG_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    `FMS_NEVER(a_cnt_cap, aclk, aresetn, cnt_reg > CAP_C)
    `FMS_ASSERT(a_load_free, aclk, aresetn, cmd.out_load |-> st.out_free)
    `FMS_ASSERT(a_end_leaves, aclk, aresetn, (in_valid && in_ready && in_last) |=> (state_reg != ST_LOAD))
    `FMS_ASSERT(a_stage_range, aclk, aresetn, (state_reg == ST_BF_RD) |-> (stage_reg != '0 && stage_reg <= lg_reg))

endmodule

// File: design/fft_magnitude_spectrum.sv
// top level of the radix-2 fft magnitude spectrum block
// Samples are taken one a cycle until an item marked frame_end; the frame is padded with
// zeros to n, the next power of two (n up to the largest power of two not above MAX_POINTS,
// at most 128), and transformed in place in a single-port-write working store by one shared
// butterfly unit. Per frame after the last sample the block sizes the frame, pads it to n,
// runs the bit-reversal pass over swapped pairs, performs (n/2)*log2(n) butterflies and then
// outputs n/2 bins, each through a 24-step bit-serial square root; the result side can stall
// the bin output. No new sample is taken until the frame's last bin has been placed in the
// output register.
module fft_magnitude_spectrum #(
    parameter int MAX_POINTS = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fms_pkg::fms_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output fms_pkg::fms_out_t m_item
);
    import fms_pkg::*;

    localparam int LIM = (MAX_POINTS < 128) ? MAX_POINTS : 128;
    localparam int AW  = $clog2(LIM + 1) - 1;

    fms_cmd_t      cmd;
    fms_stat_t     st;
    logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;

    fms_ctrl #(
        .AW(AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_last  (s_item.frame_end),
        .in_ready (s_ready),
        .st       (st),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1)
    );

    fms_datapath #(
        .AW(AW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .sample   (s_item.sample),
        .wr_addr  (wr_addr),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule
